FILE: sv/lzw_byte_stream_encoder_top_macros.svh
// Assertion helpers used by the encoder back end (lzwe_back).
`ifndef LZW_BYTE_STREAM_ENCODER_TOP_MACROS_SVH
`define LZW_BYTE_STREAM_ENCODER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LZWE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzwe assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LZWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzwe assertion failed");

`endif

FILE: sv/lzwe_pkg.sv
package lzwe_pkg;

    localparam int BYTE_W     = 8;
    localparam int FIRST_FREE = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
        logic              starts;
    } item_t;

endpackage

FILE: sv/lzw_byte_stream_encoder_top.sv
// LZW encoder with fixed CODE_WIDTH-bit codes, one source byte per input transfer.
// Input channel: in_valid/in_stall carry data_byte and final_byte; final_byte marks
// the last byte of a stream. Output channel: out_valid/out_stall carry code_word and
// stream_end, which is set on the last code of a stream. A byte produces no code, one
// code, or two codes when a mismatch meets the final byte.
// A two-entry queue takes bytes while the dictionary engine works on an earlier one.
// The engine uses a hashed table of codes with linear probing and an entry memory,
// each with a registered read. A byte that opens a stream goes from S_IDLE straight to
// S_FIN. Any other byte starts in S_IDLE; each probe that reads an entry passes S_HREAD,
// S_ENT and S_CMP; the probe that finds a free slot ends in S_MISS; the byte then
// finishes in S_FIN.
// Results pass through a four-entry output queue, so the engine goes on while a result
// waits; when out_stall holds, the engine halts once that queue cannot take two codes,
// and then in_stall rises once the input queue is full.
// Reset clears the queues and starts a fresh dictionary at once: table slots are
// checked against live codes, so no clearing pass is needed.
module lzw_byte_stream_encoder_top #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lzwe_pkg::BYTE_W-1:0] data_byte,
    input  logic                        final_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [CODE_WIDTH-1:0]       code_word,
    output logic                        stream_end
);

    logic            item_valid;
    lzwe_pkg::item_t item;
    logic            item_pop;

    lzwe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    lzwe_back #(.CODE_WIDTH(CODE_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_word  (code_word),
        .stream_end (stream_end)
    );

endmodule

FILE: sv/lzwe_ram.sv
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/lzwe_front.sv
module lzwe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lzwe_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         final_byte,
    output logic                         item_valid,
    output lzwe_pkg::item_t              item,
    input  logic                         item_pop
);

    // Two-entry queue; each byte is tagged with whether it opens a stream.
    lzwe_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            first_reg;
    logic            push;
    logic            pop;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            if (push)
            begin
                q_reg[wr_ptr_reg] <= '{data_byte: data_byte, final_byte: final_byte,
                                       starts: first_reg};
                wr_ptr_reg <= !wr_ptr_reg;
                first_reg  <= final_byte;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: sv/lzwe_back.sv
`include "lzw_byte_stream_encoder_top_macros.svh"

module lzwe_back #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  lzwe_pkg::item_t       item,
    output logic                  item_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CODE_WIDTH-1:0] code_word,
    output logic                  stream_end
);

    localparam int W  = CODE_WIDTH;
    localparam int EW = 2 * W + lzwe_pkg::BYTE_W;

    typedef enum logic [2:0] {S_IDLE, S_HREAD, S_ENT, S_CMP, S_MISS, S_FIN} state_t;

    state_t                     state_reg;
    logic [lzwe_pkg::BYTE_W-1:0] byte_reg;
    logic                       last_reg;
    logic                       miss_reg;
    logic [W-1:0]               prefix_reg;
    logic [W-1:0]               slot_reg;
    logic [W-1:0]               code_reg;
    logic [W:0]                 nf_reg;

    logic [W-1:0] oq_code_reg [4];
    logic         oq_end_reg  [4];
    logic [1:0]   oq_wr_reg;
    logic [1:0]   oq_rd_reg;
    logic [2:0]   oq_count_reg;

    logic [W-1:0]  hash_q;
    logic [EW-1:0] ent_q;
    logic [W-1:0]  hash_slot;
    logic          hash_wr;
    logic          in_range;
    logic [W-1:0]  ent_parent;
    logic [lzwe_pkg::BYTE_W-1:0] ent_byte;
    logic [W-1:0]  ent_slot;
    logic          fin_go;
    logic          out_pop;
    logic [2:0]    n_push;

    // A hash slot is occupied only if its code is live and that entry points back at it,
    // so the table needs no clearing between streams.
    assign hash_slot  = prefix_reg ^ {item.data_byte, {(W - lzwe_pkg::BYTE_W){1'b0}}};
    assign hash_wr    = (state_reg == S_MISS) && !nf_reg[W];
    assign in_range   = ({1'b0, hash_q} >= (W+1)'(lzwe_pkg::FIRST_FREE)) &&
                        ({1'b0, hash_q} < nf_reg);
    assign ent_parent = ent_q[EW-1:W+lzwe_pkg::BYTE_W];
    assign ent_byte   = ent_q[W+lzwe_pkg::BYTE_W-1:W];
    assign ent_slot   = ent_q[W-1:0];
    assign item_pop   = (state_reg == S_IDLE) && item_valid;
    assign fin_go     = (state_reg == S_FIN) && (oq_count_reg <= 3'd2);
    assign out_valid  = (oq_count_reg != 3'd0);
    assign out_pop    = out_valid && !out_stall;
    assign code_word  = oq_code_reg[oq_rd_reg];
    assign stream_end = oq_end_reg[oq_rd_reg];
    assign n_push     = fin_go ? (3'(miss_reg) + 3'(last_reg)) : 3'd0;

    lzwe_ram #(.WIDTH(W), .DEPTH(1 << W)) u_hash (
        .clk     (clk),
        .wr_en   (hash_wr),
        .wr_addr (slot_reg),
        .wr_data (nf_reg[W-1:0]),
        .rd_addr (slot_reg),
        .rd_data (hash_q)
    );

    lzwe_ram #(.WIDTH(EW), .DEPTH(1 << W)) u_entry (
        .clk     (clk),
        .wr_en   (hash_wr),
        .wr_addr (nf_reg[W-1:0]),
        .wr_data ({prefix_reg, byte_reg, slot_reg}),
        .rd_addr (hash_q),
        .rd_data (ent_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            nf_reg       <= (W+1)'(lzwe_pkg::FIRST_FREE);
            prefix_reg   <= '0;
            miss_reg     <= 1'b0;
            last_reg     <= 1'b0;
            oq_wr_reg    <= 2'd0;
            oq_rd_reg    <= 2'd0;
            oq_count_reg <= 3'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        byte_reg <= item.data_byte;
                        last_reg <= item.final_byte;
                        miss_reg <= 1'b0;
                        slot_reg <= hash_slot;
                        if (item.starts)
                        begin
                            prefix_reg <= W'(item.data_byte);
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_HREAD;
                        end
                    end
                end
                S_HREAD:
                begin
                    state_reg <= S_ENT;
                end
                S_ENT:
                begin
                    code_reg <= hash_q;
                    if (in_range)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_MISS;
                    end
                end
                S_CMP:
                begin
                    if (ent_slot == slot_reg)
                    begin
                        if (ent_parent == prefix_reg && ent_byte == byte_reg)
                        begin
                            prefix_reg <= code_reg;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + W'(1);
                            state_reg <= S_HREAD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_MISS;
                    end
                end
                S_MISS:
                begin
                    code_reg   <= prefix_reg;
                    prefix_reg <= W'(byte_reg);
                    miss_reg   <= 1'b1;
                    if (!nf_reg[W])
                    begin
                        nf_reg <= nf_reg + (W+1)'(1);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        if (miss_reg)
                        begin
                            oq_code_reg[oq_wr_reg] <= code_reg;
                            oq_end_reg[oq_wr_reg]  <= 1'b0;
                            if (last_reg)
                            begin
                                oq_code_reg[oq_wr_reg + 2'd1] <= prefix_reg;
                                oq_end_reg[oq_wr_reg + 2'd1]  <= 1'b1;
                            end
                        end
                        else if (last_reg)
                        begin
                            oq_code_reg[oq_wr_reg] <= prefix_reg;
                            oq_end_reg[oq_wr_reg]  <= 1'b1;
                        end
                        if (last_reg)
                        begin
                            nf_reg     <= (W+1)'(lzwe_pkg::FIRST_FREE);
                            prefix_reg <= '0;
                        end
                        oq_wr_reg <= oq_wr_reg + n_push[1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 2'd1;
            end
            oq_count_reg <= oq_count_reg + n_push - 3'(out_pop);
        end
    end

    `LZWE_ASSERT_NOW(a_queue_bound, 1'b1, oq_count_reg <= 3'd4)
    `LZWE_ASSERT_NOW(a_nf_floor, 1'b1, nf_reg >= (W+1)'(lzwe_pkg::FIRST_FREE))
    `LZWE_ASSERT_NEXT(a_fin_done, fin_go, state_reg == S_IDLE)
    `LZWE_ASSERT_NEXT(a_stream_reset, fin_go && last_reg,
                      nf_reg == (W+1)'(lzwe_pkg::FIRST_FREE))

endmodule
